// ===== hdl/fifo_queue_macros.svh =====
// ---------------------------------------------------------------------------
// fifo_queue_macros.svh
// Assertion helpers used by the queue datapath.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_MACROS_SVH
`define FIFO_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fq_pkg.sv =====
// ---------------------------------------------------------------------------
// fq_pkg
// Shared types and constants for the first-in first-out queue.
// ---------------------------------------------------------------------------
package fq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int ACTION_WIDTH = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_ENQ = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_DEQ = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_CLR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } fq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic exec;      // apply the action, read the slot at the old head
      logic read;      // read the slot at the new head
      logic load_rsp;  // load the response registers
   } fq_cmd_type;

endpackage

// ===== hdl/fq_ctrl.sv =====
// ---------------------------------------------------------------------------
// fq_ctrl
// Sequencer for one request at a time and the response valid flag.
// ---------------------------------------------------------------------------
module fq_ctrl
   import fq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output fq_cmd_type cmd
);

   fq_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // The response register is free once its previous result is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/fq_datapath.sv =====
// ---------------------------------------------------------------------------
// fq_datapath
// Ring buffer storage, pointers, occupancy and response registers.
// ---------------------------------------------------------------------------
`include "fifo_queue_macros.svh"

module fq_datapath
   import fq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int PW         = $clog2(DEPTH),
   parameter int CW         = $clog2(DEPTH + 1)
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  fq_cmd_type                   cmd,
   input  logic [ACTION_WIDTH-1:0]      req_action,
   input  logic signed [DATA_WIDTH-1:0] req_data_in,
   output logic signed [DATA_WIDTH-1:0] rsp_data_out,
   output logic                         rsp_ok,
   output logic signed [DATA_WIDTH-1:0] rsp_head_value,
   output logic [CW-1:0]                rsp_occupancy,
   output logic                         rsp_is_empty
);

   logic [DATA_WIDTH-1:0]   mem [DEPTH];

   logic [ACTION_WIDTH-1:0] action_ff;
   logic [DATA_WIDTH-1:0]   data_ff;
   logic [PW-1:0]           rp_ff, rp_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    ok_ff, ok_in;
   logic                    wr_en;
   logic [DATA_WIDTH-1:0]   rd_ff;
   logic [DATA_WIDTH-1:0]   removed_ff;

   logic [DATA_WIDTH-1:0]   out_data_ff;
   logic                    out_ok_ff;
   logic [DATA_WIDTH-1:0]   out_head_ff;
   logic [CW-1:0]           out_count_ff;
   logic                    out_empty_ff;

   logic [CW:0]             ptr_sum;
   logic [CW:0]             ptr_wrap;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         data_ff   <= req_data_in;
      end
   end

   always_comb begin
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      if (cmd.exec) begin
         ok_in = 1'b0;
         case (action_ff)
            ACT_ENQ: begin
               if (count_ff != CW'(DEPTH)) begin
                  wr_en    = 1'b1;
                  wp_in    = advance(wp_ff);
                  count_in = count_ff + 1'b1;
                  ok_in    = 1'b1;
               end
            end
            ACT_DEQ: begin
               if (count_ff != '0) begin
                  rp_in    = advance(rp_ff);
                  count_in = count_ff - 1'b1;
                  ok_in    = 1'b1;
               end
            end
            ACT_CLR: begin
               rp_in    = '0;
               wp_in    = '0;
               count_in = '0;
               ok_in    = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff    <= '0;
         wp_ff    <= '0;
         count_ff <= '0;
      end else begin
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   // Single read port at the head pointer: during execution it returns the
   // slot being removed, in the following read step the slot at the new head.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= data_ff;
      end
      if (cmd.exec || cmd.read) begin
         rd_ff <= mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         removed_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_data_ff  <= (ok_ff && action_ff == ACT_DEQ) ? removed_ff : '0;
         out_ok_ff    <= ok_ff;
         out_head_ff  <= (count_ff != '0) ? rd_ff : '0;
         out_count_ff <= count_ff;
         out_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_data_out   = out_data_ff;
   assign rsp_ok         = out_ok_ff;
   assign rsp_head_value = out_head_ff;
   assign rsp_occupancy  = out_count_ff;
   assign rsp_is_empty   = out_empty_ff;

   // Expected write pointer from the head pointer and the occupancy.
   assign ptr_sum  = (CW + 1)'(rp_ff) + (CW + 1)'(count_ff);
   assign ptr_wrap = (ptr_sum >= (CW + 1)'(DEPTH)) ? ptr_sum - (CW + 1)'(DEPTH) : ptr_sum;

   `FQ_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(DEPTH),
                   "occupancy exceeds the queue depth")
   `FQ_ASSERT_IMPL(a_ptr_consistent, 1'b1, ptr_wrap == (CW + 1)'(wp_ff),
                   "write pointer disagrees with head pointer plus occupancy")
   `FQ_ASSERT_NEXT(a_enq_count, cmd.exec && action_ff == ACT_ENQ && count_ff != CW'(DEPTH),
                   count_ff == $past(count_ff) + 1'b1,
                   "accepted enqueue did not raise the occupancy by one")

endmodule

// ===== hdl/fifo_queue.sv =====
// ---------------------------------------------------------------------------
// fifo_queue
// First-in first-out queue of signed words in a ring buffer.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_ready  req_action, req_data_in
//  rsp       out        rsp_valid/rsp_ready  rsp_data_out, rsp_ok, rsp_head_value,
//                                            rsp_occupancy, rsp_is_empty
//
// A request passes through the accept, execute, head read and response load
// steps in that order. A new request is taken only after the previous one
// has been loaded into the response registers. Reset clears pointers,
// occupancy and control state, not the slot memory. A stalled response
// holds the sequencer in its last step; a new request is still taken
// while a finished response waits.
// ---------------------------------------------------------------------------
module fifo_queue
   import fq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ACTION_WIDTH-1:0]          req_action,
   input  logic signed [DATA_WIDTH-1:0]     req_data_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [DATA_WIDTH-1:0]     rsp_data_out,
   output logic                             rsp_ok,
   output logic signed [DATA_WIDTH-1:0]     rsp_head_value,
   output logic [$clog2(DEPTH + 1)-1:0]     rsp_occupancy,
   output logic                             rsp_is_empty
);

   fq_cmd_type cmd;

   fq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   fq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .rsp_data_out   (rsp_data_out),
      .rsp_ok         (rsp_ok),
      .rsp_head_value (rsp_head_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

// ===== tb/sv/fifo_queue_tb.sv =====
// ---------------------------------------------------------------------------
// fifo_queue_tb
// Self-checking testbench for the first-in first-out queue.
//
// Requests are driven on the falling edge with random gaps, and responses
// are taken on the rising edge with random stalls. A ring-buffer predictor
// computes every response when its request is accepted, and the checker
// compares each response field by field in order. Directed cases cover the
// value extremes, refusals on full and empty, the clear and the unused code.
// Random traffic is biased to sweep the queue between empty and full.
// ---------------------------------------------------------------------------
module fifo_queue_tb
   import fq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = DEPTH_DEFAULT;
   localparam int DATA_WIDTH = DATA_WIDTH_DEFAULT;
   localparam int OCC_WIDTH  = $clog2(DEPTH + 1);
   localparam int PTR_WIDTH  = $clog2(DEPTH);

   // The fourth action code has no meaning and must act as a refused no-op.
   localparam logic [ACTION_WIDTH-1:0] ACT_NOP = 2'd3;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int TAIL_CYCLES     = 20;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] data_out;
      logic                         ok;
      logic signed [DATA_WIDTH-1:0] head_value;
      logic [OCC_WIDTH-1:0]         occupancy;
      logic                         is_empty;
   } queue_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [ACTION_WIDTH-1:0]       req_action;
   logic signed [DATA_WIDTH-1:0]  req_data_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [DATA_WIDTH-1:0]  rsp_data_out;
   logic                          rsp_ok;
   logic signed [DATA_WIDTH-1:0]  rsp_head_value;
   logic [OCC_WIDTH-1:0]          rsp_occupancy;
   logic                          rsp_is_empty;

   // Predictor state: a ring buffer mirroring the queue.
   logic signed [DATA_WIDTH-1:0]  slot_copy [DEPTH];
   logic [PTR_WIDTH-1:0]          head_ptr;
   logic [PTR_WIDTH-1:0]          tail_ptr;
   int                            fill_count;

   queue_result_type              pending_results [$];

   int  mismatch_count   = 0;
   int  requests_sent    = 0;
   int  responses_seen   = 0;
   int  full_refusals    = 0;
   int  empty_refusals   = 0;
   int  clears_seen      = 0;
   int  hold_request     = 0;
   bit  sender_idle_on   = 1'b1;
   bit  receiver_idle_on = 1'b1;

   fifo_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_ok         (rsp_ok),
      .rsp_head_value (rsp_head_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Timeout while waiting for the queue");
      $display("Test completed with failures");
      $finish;
   end

   // Applies one accepted request to the ring buffer and queues its response.
   task automatic apply_to_queue(input logic [ACTION_WIDTH-1:0] act,
                                 input logic signed [DATA_WIDTH-1:0] val);
      queue_result_type res;
      res.data_out = '0;
      res.ok       = 1'b0;
      case (act)
         ACT_ENQ: begin
            if (fill_count < DEPTH) begin
               slot_copy[tail_ptr] = val;
               tail_ptr            = (tail_ptr == DEPTH - 1) ? '0 : tail_ptr + 1'b1;
               fill_count++;
               res.ok = 1'b1;
            end else begin
               full_refusals++;
            end
         end
         ACT_DEQ: begin
            if (fill_count > 0) begin
               res.data_out = slot_copy[head_ptr];
               head_ptr     = (head_ptr == DEPTH - 1) ? '0 : head_ptr + 1'b1;
               fill_count--;
               res.ok = 1'b1;
            end else begin
               empty_refusals++;
            end
         end
         ACT_CLR: begin
            head_ptr   = '0;
            tail_ptr   = '0;
            fill_count = 0;
            res.ok     = 1'b1;
            clears_seen++;
         end
         default: ;
      endcase
      res.head_value = (fill_count > 0) ? slot_copy[head_ptr] : '0;
      res.occupancy  = fill_count[OCC_WIDTH-1:0];
      res.is_empty   = (fill_count == 0);
      pending_results.push_back(res);
   endtask

   // Offers one request, after a random gap while gaps are enabled, and returns at the accepting edge.
   task automatic send_request(input logic [ACTION_WIDTH-1:0] act,
                               input logic signed [DATA_WIDTH-1:0] val);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_data_in <= val;
      do @(posedge clock); while (!req_ready);
      apply_to_queue(act, val);
      requests_sent++;
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Picks an action with the given share of enqueues among the data actions.
   function automatic logic [ACTION_WIDTH-1:0] random_action(input int enq_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return ACT_CLR;
      else if (r < 6)
         return ACT_NOP;
      else if (r < 6 + (enq_pct * 94) / 100)
         return ACT_ENQ;
      else
         return ACT_DEQ;
   endfunction

   task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] expected,
                              input logic [DATA_WIDTH-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // Response side: stalls at random, honors a requested hold-off, checks results.
   initial begin : response_side
      int               rsp_wait;
      queue_result_type exp_r;
      rsp_wait  = 0;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_wait     = hold_request;
            hold_request = 0;
         end
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_count++;
            end else begin
               exp_r = pending_results.pop_front();
               check_field("data_out", exp_r.data_out, rsp_data_out);
               check_field("ok", DATA_WIDTH'(exp_r.ok), DATA_WIDTH'(rsp_ok));
               check_field("head_value", exp_r.head_value, rsp_head_value);
               check_field("occupancy", DATA_WIDTH'(exp_r.occupancy),
                           DATA_WIDTH'(rsp_occupancy));
               check_field("is_empty", DATA_WIDTH'(exp_r.is_empty),
                           DATA_WIDTH'(rsp_is_empty));
            end
            responses_seen++;
            rsp_wait = receiver_idle_on ? $urandom_range(0, 3) : 0;
         end
      end
   end

   task automatic test_directed();
      logic signed [DATA_WIDTH-1:0] values [6];
      values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                 32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555};
      send_request(ACT_DEQ, 32'sh1234_5678);   // dequeue from an empty queue
      send_request(ACT_NOP, 32'sh0BAD_F00D);
      for (int i = 0; i < DEPTH; i++)
         send_request(ACT_ENQ, (i < 6) ? values[i] : random_word());
      send_request(ACT_ENQ, 32'sh7FFF_FFFF);   // refused: the queue is full
      send_request(ACT_DEQ, 32'sh0);
      send_request(ACT_NOP, 32'shFFFF_FFFF);
      send_request(ACT_CLR, 32'sh0);
      send_request(ACT_DEQ, 32'sh0);
      send_request(ACT_ENQ, 32'sh8000_0001);   // first write after a clear
      send_request(ACT_DEQ, 32'sh0);
   endtask

   task automatic test_random_traffic(input int count);
      int enq_pct;
      enq_pct = 50;
      for (int i = 0; i < count; i++) begin
         // Change the mix now and then so the queue swings between empty and full.
         if (i % 60 == 0)
            case ($urandom_range(0, 4))
               0: enq_pct = 10;
               1: enq_pct = 30;
               2: enq_pct = 50;
               3: enq_pct = 75;
               default: enq_pct = 92;
            endcase
         send_request(random_action(enq_pct), random_word());
      end
   endtask

   task automatic test_backpressure(input int count);
      sender_idle_on = 1'b0;
      hold_request   = HOLD_OFF_CYCLES;
      for (int i = 0; i < count; i++)
         send_request(random_action(80), random_word());
      sender_idle_on = 1'b1;
   endtask

   task automatic test_drain_pause(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         for (int i = 0; i < 20; i++)
            send_request(random_action(60), random_word());
         @(negedge clock);
         req_valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
      end
   endtask

   task automatic test_streaming(input int count);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_request(random_action((i / 50) % 2 ? 30 : 70), random_word());
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_action  = ACT_ENQ;
      req_data_in = '0;
      head_ptr    = '0;
      tail_ptr    = '0;
      fill_count  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(1200);
      test_backpressure(40);
      test_drain_pause(10);
      test_streaming(300);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses.", requests_sent, responses_seen);
      $display("Refused %0d enqueues on full, %0d dequeues on empty; %0d clears.",
               full_refusals, empty_refusals, clears_seen);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fq_pkg.sv
hdl/fq_ctrl.sv
hdl/fq_datapath.sv
hdl/fifo_queue.sv
tb/sv/fifo_queue_tb.sv
